FILE: rtl/serial_camera_pixel_capture_unit_defines.svh
// ----------------------------------------------------------------------------
// Serial camera pixel capture: assertion macros
// Shared helpers for the concurrent checks on the capture unit's ports.
// ----------------------------------------------------------------------------
`ifndef SERIAL_CAMERA_PIXEL_CAPTURE_UNIT_DEFINES_SVH
`define SERIAL_CAMERA_PIXEL_CAPTURE_UNIT_DEFINES_SVH

// Generic clocked assertion with an active-low reset that disables it.
`define SCPC_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the house clock and reset names.
`define SCPC_ASSERT(lbl, prop, msg) \
  `SCPC_ASSERT_RST(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/scpc_pkg.sv
// ----------------------------------------------------------------------------
// Serial camera pixel capture package
// Types, codes and sizes shared by the capture unit's modules.
// ----------------------------------------------------------------------------
package scpc_pkg;

  localparam int unsigned PIXEL_BITS    = 8;
  localparam int unsigned BUFFER_DEPTH  = 65536;
  localparam int unsigned WAIT_W        = 24;
  localparam int unsigned ROWLEN_W      = 11;
  localparam int unsigned COUNT_W       = 10;
  localparam int unsigned FRAME_W       = 16;
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned BIT_IDX_W     = 3;
  localparam int unsigned ADDR_W        = 16;
  localparam int unsigned PROD_W        = COUNT_W + ROWLEN_W;
  localparam int unsigned SUM_W         = PROD_W + 1;
  localparam int unsigned CFG_DATA_W    = 24;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W   = QUEUE_PTR_W + 1;
  localparam int unsigned COUNT_MAX     = (1 << COUNT_W) - 1;
  localparam int unsigned WAIT_RESET    = 65535;
  localparam int unsigned ROWLEN_RESET  = 320;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_WAIT    = 2'd1,
    PH_CAPTURE = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_FRAME   = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAIT_LIMIT = 1'd0,
    CFG_ROW_LENGTH = 1'd1
  } cfg_reg_e;

  // Classified event passed from the front end to the back end.
  typedef struct packed {
    kind_e               kind;
    logic [PIX_W-1:0]    pixel;
    logic [COUNT_W-1:0]  row;
    logic [COUNT_W-1:0]  column;
    logic [FRAME_W-1:0]  frames;
  } scpc_event_t;

endpackage

FILE: rtl/scpc_if.sv
// ----------------------------------------------------------------------------
// Serial camera pixel capture channels
// Valid/ready channels for pin samples, results and register writes.
// ----------------------------------------------------------------------------
interface scpc_pix_if;
  logic valid;
  logic ready;
  logic mode;
  logic vsync;
  logic hsync;
  logic pixel_clock;
  logic data_bit;

  modport source (output valid, mode, vsync, hsync, pixel_clock, data_bit, input ready);
  modport sink   (input valid, mode, vsync, hsync, pixel_clock, data_bit, output ready);
  modport mon    (input valid, ready, mode, vsync, hsync, pixel_clock, data_bit);
endinterface

interface scpc_res_if import scpc_pkg::*;;
  logic               valid;
  logic               ready;
  kind_e              kind;
  logic [PIX_W-1:0]   pixel_value;
  logic [ADDR_W-1:0]  buffer_address;
  logic [COUNT_W-1:0] row_index;
  logic [COUNT_W-1:0] column_index;
  logic               out_of_range;
  logic [FRAME_W-1:0] frames_taken;

  modport source (output valid, kind, pixel_value, buffer_address, row_index, column_index,
                  out_of_range, frames_taken, input ready);
  modport sink   (input valid, kind, pixel_value, buffer_address, row_index, column_index,
                  out_of_range, frames_taken, output ready);
  modport mon    (input valid, ready, kind, pixel_value, buffer_address, row_index,
                  column_index, out_of_range, frames_taken);
endinterface

interface scpc_cfg_if import scpc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
  modport mon    (input valid, ready, index, data);
endinterface

FILE: rtl/scpc_front.sv
// ----------------------------------------------------------------------------
// Serial camera pixel capture: front end
// Accepts pin samples and arm commands, tracks the capture state and
// classifies items into pixel, frame-done and timeout events.
// ----------------------------------------------------------------------------
module scpc_front import scpc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  scpc_pix_if.sink          pix_i,
  input  logic [WAIT_W-1:0] wait_limit_i,
  output logic              ev_valid_o,
  output scpc_event_t       ev_o,
  input  logic              ev_ready_i
);

  phase_e                 phase_q, phase_d;
  logic [WAIT_W-1:0]      wait_count_q, wait_count_d;
  logic                   last_pclk_q, last_pclk_d;
  logic                   last_hsync_q, last_hsync_d;
  logic [BIT_IDX_W-1:0]   bit_index_q, bit_index_d;
  logic [PIX_W-1:0]       shift_q, shift_d;
  logic [COUNT_W-1:0]     row_q, row_d;
  logic [COUNT_W-1:0]     column_q, column_d;
  logic [FRAME_W-1:0]     frames_q, frames_d;
  logic                   accept;
  logic                   pclk_fall;
  logic                   wait_expired;
  logic [PIX_W-1:0]       shift_next;

  assign pix_i.ready  = ev_ready_i;
  assign accept       = pix_i.valid && ev_ready_i;
  assign pclk_fall    = last_pclk_q && !pix_i.pixel_clock;
  assign wait_expired = wait_count_q >= wait_limit_i;
  assign shift_next   = shift_q | (PIX_W'(pix_i.data_bit) << bit_index_q);

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      if (pix_i.mode) begin
        phase_d = PH_WAIT;
      end else begin
        case (phase_q)
          PH_WAIT: begin
            if (pix_i.vsync) begin
              phase_d = PH_CAPTURE;
            end else if (wait_expired) begin
              phase_d = PH_IDLE;
            end
          end
          PH_CAPTURE: begin
            if (!pix_i.vsync) begin
              phase_d = PH_IDLE;
            end
          end
          default: phase_d = phase_q;
        endcase
      end
    end
  end

  always_comb begin
    wait_count_d = wait_count_q;
    last_pclk_d  = last_pclk_q;
    last_hsync_d = last_hsync_q;
    bit_index_d  = bit_index_q;
    shift_d      = shift_q;
    row_d        = row_q;
    column_d     = column_q;
    frames_d     = frames_q;
    ev_valid_o   = 1'b0;
    ev_o.kind    = KIND_PIXEL;
    ev_o.pixel   = '0;
    ev_o.row     = row_q;
    ev_o.column  = column_q;
    ev_o.frames  = frames_q;
    if (accept) begin
      if (pix_i.mode) begin
        wait_count_d = '0;
        row_d        = '0;
        column_d     = '0;
        bit_index_d  = '0;
        shift_d      = '0;
      end else begin
        last_pclk_d  = pix_i.pixel_clock;
        last_hsync_d = pix_i.hsync;
        case (phase_q)
          PH_WAIT: begin
            if (pix_i.vsync) begin
              bit_index_d = '0;
              shift_d     = '0;
            end else if (wait_expired) begin
              ev_valid_o = 1'b1;
              ev_o.kind  = KIND_TIMEOUT;
            end else begin
              wait_count_d = wait_count_q + WAIT_W'(1);
            end
          end
          PH_CAPTURE: begin
            if (!pix_i.vsync) begin
              bit_index_d = '0;
              shift_d     = '0;
              frames_d    = frames_q + FRAME_W'(1);
              ev_valid_o  = 1'b1;
              ev_o.kind   = KIND_FRAME;
              ev_o.frames = frames_d;
            end else if (pix_i.hsync) begin
              if (pclk_fall) begin
                if (bit_index_q == BIT_IDX_W'(PIXEL_BITS - 1)) begin
                  ev_valid_o  = 1'b1;
                  ev_o.kind   = KIND_PIXEL;
                  ev_o.pixel  = shift_next;
                  bit_index_d = '0;
                  shift_d     = '0;
                  if (column_q != COUNT_W'(COUNT_MAX)) begin
                    column_d = column_q + COUNT_W'(1);
                  end
                end else begin
                  shift_d     = shift_next;
                  bit_index_d = bit_index_q + BIT_IDX_W'(1);
                end
              end
            end else if (last_hsync_q) begin
              if (row_q != COUNT_W'(COUNT_MAX)) begin
                row_d = row_q + COUNT_W'(1);
              end
              column_d    = '0;
              bit_index_d = '0;
              shift_d     = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      wait_count_q <= '0;
      last_pclk_q  <= 1'b0;
      last_hsync_q <= 1'b0;
      bit_index_q  <= '0;
      shift_q      <= '0;
      row_q        <= '0;
      column_q     <= '0;
      frames_q     <= '0;
    end else begin
      phase_q      <= phase_d;
      wait_count_q <= wait_count_d;
      last_pclk_q  <= last_pclk_d;
      last_hsync_q <= last_hsync_d;
      bit_index_q  <= bit_index_d;
      shift_q      <= shift_d;
      row_q        <= row_d;
      column_q     <= column_d;
      frames_q     <= frames_d;
    end
  end

endmodule

FILE: rtl/scpc_queue.sv
// ----------------------------------------------------------------------------
// Serial camera pixel capture: event queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module scpc_queue import scpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  input  scpc_event_t push_data_i,
  output logic        push_ready_o,
  output logic        pop_valid_o,
  output scpc_event_t pop_data_o,
  input  logic        pop_ready_i
);

  scpc_event_t            entry_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   push;
  logic                   pop;

  assign push_ready_o = count_q != QUEUE_CNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QUEUE_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QUEUE_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: rtl/scpc_back.sv
// ----------------------------------------------------------------------------
// Serial camera pixel capture: back end
// Works out the buffer address of each pixel event in two stages (row
// product, then column add and range check) and holds the result item.
// ----------------------------------------------------------------------------
module scpc_back import scpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                ev_valid_i,
  input  scpc_event_t         ev_i,
  output logic                ev_ready_o,
  input  logic [ROWLEN_W-1:0] row_length_i,
  scpc_res_if.source          res_o
);

  logic               prod_valid_q;
  scpc_event_t        prod_ev_q;
  logic [PROD_W-1:0]  prod_q;
  logic               prod_ready;
  logic               out_valid_q;
  kind_e              kind_q;
  logic [PIX_W-1:0]   pixel_q;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [COUNT_W-1:0] row_q;
  logic [COUNT_W-1:0] column_q;
  logic               oor_q, oor_d;
  logic [FRAME_W-1:0] frames_q;
  logic               out_ready;
  logic [SUM_W-1:0]   sum;

  assign out_ready  = !out_valid_q || res_o.ready;
  assign prod_ready = !prod_valid_q || out_ready;
  assign ev_ready_o = prod_ready;

  assign sum = SUM_W'(prod_q) + SUM_W'(prod_ev_q.column);

  always_comb begin
    oor_d  = 1'b0;
    addr_d = '0;
    if (prod_ev_q.kind == KIND_PIXEL) begin
      oor_d  = sum >= SUM_W'(BUFFER_DEPTH);
      addr_d = oor_d ? '0 : sum[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_ready && ev_valid_i) begin
      prod_ev_q <= ev_i;
      prod_q    <= PROD_W'(ev_i.row) * PROD_W'(row_length_i);
    end
    if (out_ready && prod_valid_q) begin
      kind_q   <= prod_ev_q.kind;
      pixel_q  <= prod_ev_q.pixel;
      addr_q   <= addr_d;
      row_q    <= prod_ev_q.row;
      column_q <= prod_ev_q.column;
      oor_q    <= oor_d;
      frames_q <= prod_ev_q.frames;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid_q <= ev_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= prod_valid_q;
      end
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.kind           = kind_q;
  assign res_o.pixel_value    = pixel_q;
  assign res_o.buffer_address = addr_q;
  assign res_o.row_index      = row_q;
  assign res_o.column_index   = column_q;
  assign res_o.out_of_range   = oor_q;
  assign res_o.frames_taken   = frames_q;

endmodule

FILE: rtl/serial_camera_pixel_capture_unit.sv
// ----------------------------------------------------------------------------
// Serial camera pixel capture unit
// Samples camera sync, clock and data pins, assembles serial pixels and
// reports each pixel with its position, plus frame-done and timeout items.
//
//   Channel  Direction  Carries
//   pix_i    in         mode, vsync, hsync, pixel_clock, data_bit
//   res_o    out        kind, pixel_value, buffer_address, row/column index,
//                       out_of_range, frames_taken
//   cfg_i    in         index, data (wait limit, row length)
//
// One item is accepted per cycle while the event queue has room; each result
// passes through the event queue, the row-length multiplier stage and the
// output register before it leaves.
// A four-entry event queue lets the front end keep sampling while res_o stalls;
// pix_i drops ready only when that queue is full. Reset clears the control
// state and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module serial_camera_pixel_capture_unit import scpc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  scpc_pix_if.sink   pix_i,
  scpc_res_if.source res_o,
  scpc_cfg_if.sink   cfg_i
);

  logic [WAIT_W-1:0]   wait_limit_q;
  logic [ROWLEN_W-1:0] row_length_q;
  logic                fe_valid;
  scpc_event_t         fe_event;
  logic                fe_ready;
  logic                be_valid;
  scpc_event_t         be_event;
  logic                be_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_limit_q <= WAIT_W'(WAIT_RESET);
      row_length_q <= ROWLEN_W'(ROWLEN_RESET);
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_WAIT_LIMIT: wait_limit_q <= cfg_i.data[WAIT_W-1:0];
        CFG_ROW_LENGTH: row_length_q <= cfg_i.data[ROWLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  scpc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix_i),
    .wait_limit_i (wait_limit_q),
    .ev_valid_o   (fe_valid),
    .ev_o         (fe_event),
    .ev_ready_i   (fe_ready)
  );

  scpc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_data_i  (fe_event),
    .push_ready_o (fe_ready),
    .pop_valid_o  (be_valid),
    .pop_data_o   (be_event),
    .pop_ready_i  (be_ready)
  );

  scpc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ev_valid_i   (be_valid),
    .ev_i         (be_event),
    .ev_ready_o   (be_ready),
    .row_length_i (row_length_q),
    .res_o        (res_o)
  );

endmodule

FILE: rtl/scpc_checker.sv
// ----------------------------------------------------------------------------
// Serial camera pixel capture: port checker
// Concurrent checks on the result and configuration channels of the unit.
// ----------------------------------------------------------------------------
`include "serial_camera_pixel_capture_unit_defines.svh"

module scpc_checker import scpc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input kind_e              res_kind_i,
  input logic [PIX_W-1:0]   res_pixel_i,
  input logic [ADDR_W-1:0]  res_addr_i,
  input logic               res_oor_i,
  input logic [FRAME_W-1:0] res_frames_i,
  input logic               cfg_ready_i
);

  logic                                          res_stall;
  logic [$bits(kind_e)+PIX_W+ADDR_W+FRAME_W-1:0] res_payload;
  logic                                          res_sync_item;
  logic                                          res_pix_empty;
  logic                                          res_oor_item;
  logic                                          res_oor_clean;

  assign res_stall     = res_valid_i && !res_ready_i;
  assign res_payload   = {res_kind_i, res_pixel_i, res_addr_i, res_frames_i};
  assign res_sync_item = res_valid_i && (res_kind_i != KIND_PIXEL);
  assign res_pix_empty = (res_pixel_i == '0) && (res_addr_i == '0) && !res_oor_i;
  assign res_oor_item  = res_valid_i && res_oor_i;
  assign res_oor_clean = (res_kind_i == KIND_PIXEL) && (res_addr_i == '0);

  `SCPC_ASSERT(a_res_valid_held, res_stall |=> res_valid_i, "result item withdrawn")
  `SCPC_ASSERT(a_res_payload_held, res_stall |=> $stable(res_payload), "stalled item changed")
  `SCPC_ASSERT(a_sync_item_clean, res_sync_item |-> res_pix_empty, "sync item has pixel data")
  `SCPC_ASSERT(a_overflow_address, res_oor_item |-> res_oor_clean, "overflow has an address")
  `SCPC_ASSERT(a_cfg_always_ready, cfg_ready_i, "register write refused")

endmodule

bind serial_camera_pixel_capture_unit scpc_checker u_scpc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_kind_i   (res_o.kind),
  .res_pixel_i  (res_o.pixel_value),
  .res_addr_i   (res_o.buffer_address),
  .res_oor_i    (res_o.out_of_range),
  .res_frames_i (res_o.frames_taken),
  .cfg_ready_i  (cfg_i.ready)
);

FILE: tb/sv/serial_camera_pixel_capture_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial camera pixel capture unit testbench
// Feeds camera pin samples, arm commands and register writes to the capture
// unit. An in-bench model of the capture logic predicts every pixel,
// frame-done and sync-timeout item. Each result is checked field by field
// while the input idles, the output stalls and the output is held off long
// enough to fill the unit's event queue.
// ----------------------------------------------------------------------------
module serial_camera_pixel_capture_unit_tb;
  import scpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 300;

  typedef struct {
    kind_e              kind;
    logic [PIX_W-1:0]   pixel;
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] row;
    logic [COUNT_W-1:0] column;
    logic               out_of_range;
    logic [FRAME_W-1:0] frames;
  } capture_result_t;

  logic clk_i;
  logic rst_ni;

  scpc_pix_if pix_ch ();
  scpc_res_if res_ch ();
  scpc_cfg_if cfg_ch ();

  serial_camera_pixel_capture_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  logic [WAIT_W-1:0]    wait_limit_q;
  logic [ROWLEN_W-1:0]  row_length_q;
  phase_e               cap_phase;
  logic [WAIT_W-1:0]    sync_wait;
  logic                 prev_pclk;
  logic                 prev_hsync;
  logic [BIT_IDX_W-1:0] bit_pos;
  logic [PIX_W-1:0]     shift_reg;
  logic [COUNT_W-1:0]   row_count;
  logic [COUNT_W-1:0]   column_count;
  logic [FRAME_W-1:0]   frame_count;

  capture_result_t awaited_results[$];

  int sender_idle_pct;
  int receiver_stall_pct;
  bit hold_toggle;
  int samples_sent;
  int live_samples;
  int results_awaited;
  int results_checked;
  int mismatch_count;
  int settings_used;
  int cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic coin();
    return 1'($urandom_range(1));
  endfunction

  function automatic void await_result(kind_e kind, logic [PIX_W-1:0] pixel,
                                       logic [ADDR_W-1:0] address, logic oor);
    capture_result_t r;
    r.kind         = kind;
    r.pixel        = pixel;
    r.address      = address;
    r.row          = row_count;
    r.column       = column_count;
    r.out_of_range = oor;
    r.frames       = frame_count;
    awaited_results.push_back(r);
    results_awaited++;
  endfunction

  function automatic void predict_capture(logic mode, logic vs, logic hs, logic pc, logic db);
    int   address;
    logic oor;
    if (mode) begin
      cap_phase    = PH_WAIT;
      sync_wait    = '0;
      row_count    = '0;
      column_count = '0;
      bit_pos      = '0;
      shift_reg    = '0;
      return;
    end
    case (cap_phase)
      PH_WAIT: begin
        if (vs) begin
          cap_phase = PH_CAPTURE;
          bit_pos   = '0;
          shift_reg = '0;
        end else if (sync_wait >= wait_limit_q) begin
          cap_phase = PH_IDLE;
          await_result(KIND_TIMEOUT, '0, '0, 1'b0);
        end else begin
          sync_wait = sync_wait + 1'b1;
        end
      end
      PH_CAPTURE: begin
        if (!vs) begin
          bit_pos     = '0;
          shift_reg   = '0;
          frame_count = frame_count + 1'b1;
          cap_phase   = PH_IDLE;
          await_result(KIND_FRAME, '0, '0, 1'b0);
        end else if (hs) begin
          if (prev_pclk && !pc) begin
            shift_reg = shift_reg | (PIX_W'(db) << bit_pos);
            if (int'(bit_pos) + 1 >= int'(PIXEL_BITS)) begin
              address = int'(row_count) * int'(row_length_q) + int'(column_count);
              oor     = (address >= int'(BUFFER_DEPTH));
              await_result(KIND_PIXEL, shift_reg, oor ? '0 : address[ADDR_W-1:0], oor);
              if (column_count < COUNT_MAX) column_count++;
              bit_pos   = '0;
              shift_reg = '0;
            end else begin
              bit_pos++;
            end
          end
        end else if (prev_hsync) begin
          if (row_count < COUNT_MAX) row_count++;
          column_count = '0;
          bit_pos      = '0;
          shift_reg    = '0;
        end
      end
      default: ;
    endcase
    prev_pclk  = pc;
    prev_hsync = hs;
  endfunction

  task automatic send_sample(logic mode, logic vs, logic hs, logic pc, logic db);
    logic   accepted;
    phase_e phase_seen;
    while ($urandom_range(99) < sender_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.mode        <= mode;
    pix_ch.vsync       <= vs;
    pix_ch.hsync       <= hs;
    pix_ch.pixel_clock <= pc;
    pix_ch.data_bit    <= db;
    do begin
      @(negedge clk_i);
      accepted = (pix_ch.ready === 1'b1);
      @(posedge clk_i);
    end while (!accepted);
    phase_seen = cap_phase;
    predict_capture(mode, vs, hs, pc, db);
    samples_sent++;
    if (mode || phase_seen != PH_IDLE) live_samples++;
  endtask

  task automatic send_arm();
    send_sample(1'b1, coin(), coin(), coin(), coin());
  endtask

  task automatic send_pixel_bits(logic [PIX_W-1:0] value, int count);
    for (int i = 0; i < count; i++) begin
      send_sample(1'b0, 1'b1, 1'b1, 1'b1, coin());
      send_sample(1'b0, 1'b1, 1'b1, 1'b0, value[i]);
    end
  endtask

  task automatic send_line(int pixels, int extra_bits);
    send_sample(1'b0, 1'b1, 1'b1, coin(), coin());
    for (int p = 0; p < pixels; p++) send_pixel_bits(PIX_W'($urandom), PIXEL_BITS);
    send_pixel_bits(PIX_W'($urandom), extra_bits);
    send_sample(1'b0, 1'b1, 1'b0, coin(), coin());
  endtask

  task automatic send_noise(int count);
    for (int i = 0; i < count; i++) begin
      send_sample($urandom_range(19) == 0, coin(), coin(), coin(), coin());
    end
  endtask

  task automatic send_frame(int waits, int lines, int max_pixels);
    send_arm();
    for (int w = 0; w < waits && cap_phase == PH_WAIT; w++) begin
      send_sample(1'b0, 1'b0, coin(), coin(), coin());
    end
    if (cap_phase != PH_WAIT) return;
    send_sample(1'b0, 1'b1, coin(), coin(), coin());
    for (int l = 0; l < lines; l++) begin
      send_line($urandom_range(0, max_pixels), $urandom_range(0, PIXEL_BITS - 1));
      if ($urandom_range(99) < 8) begin
        send_pixel_bits(PIX_W'($urandom), $urandom_range(1, PIXEL_BITS - 1));
        if (coin()) begin
          send_arm();
          return;
        end
        break;
      end
    end
    send_sample(1'b0, 1'b0, coin(), coin(), coin());
  endtask

  task automatic wait_quiet();
    pix_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_reg_e index, logic [CFG_DATA_W-1:0] value);
    logic accepted;
    wait_quiet();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= value;
    do begin
      @(negedge clk_i);
      accepted = (cfg_ch.ready === 1'b1);
      @(posedge clk_i);
    end while (!accepted);
    cfg_ch.valid <= 1'b0;
    if (index == CFG_WAIT_LIMIT) wait_limit_q = value[WAIT_W-1:0];
    else row_length_q = value[ROWLEN_W-1:0];
    settings_used++;
  endtask

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic check_result();
    capture_result_t want;
    if (awaited_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual kind %0d pixel %0h",
               $time, res_ch.kind, res_ch.pixel_value);
      mismatch_count++;
      return;
    end
    want = awaited_results.pop_front();
    results_checked++;
    compare_field("kind", want.kind, res_ch.kind);
    compare_field("pixel_value", want.pixel, res_ch.pixel_value);
    compare_field("buffer_address", want.address, res_ch.buffer_address);
    compare_field("row_index", want.row, res_ch.row_index);
    compare_field("column_index", want.column, res_ch.column_index);
    compare_field("out_of_range", want.out_of_range, res_ch.out_of_range);
    compare_field("frames_taken", want.frames, res_ch.frames_taken);
  endtask

  initial begin : result_checker
    forever begin
      @(negedge clk_i);
      if (rst_ni === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) check_result();
    end
  end

  initial begin : result_sink
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("serial_camera_pixel_capture_unit_tb: errors");
    $finish;
  end

  task automatic test_reset_defaults();
    for (int i = 0; i < 4; i++) send_sample(1'b0, coin(), coin(), coin(), coin());
    send_arm();
    send_sample(1'b0, 1'b1, 1'b0, 1'b0, coin());
    send_pixel_bits(8'hA5, PIXEL_BITS);
    send_sample(1'b0, 1'b1, 1'b0, coin(), coin());
    send_pixel_bits(8'h3C, PIXEL_BITS);
    send_sample(1'b0, 1'b0, coin(), coin(), coin());
  endtask

  task automatic test_line_and_frame_ends();
    send_arm();
    send_sample(1'b0, 1'b1, 1'b0, 1'b0, coin());
    send_pixel_bits('0, PIXEL_BITS);
    send_pixel_bits('1, PIXEL_BITS);
    send_pixel_bits(8'h5A, 5);
    send_sample(1'b0, 1'b1, 1'b0, 1'b1, coin());
    send_sample(1'b0, 1'b1, 1'b0, 1'b0, coin());
    send_line(1, 3);
    send_pixel_bits(8'hC3, 6);
    send_arm();
    send_sample(1'b0, 1'b1, 1'b1, 1'b1, coin());
    send_pixel_bits(8'h81, PIXEL_BITS);
    send_pixel_bits(8'h7E, 4);
    send_sample(1'b0, 1'b0, 1'b1, 1'b0, coin());
    send_sample(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
  endtask

  task automatic test_sync_timeout();
    write_register(CFG_WAIT_LIMIT, '0);
    send_arm();
    send_sample(1'b0, 1'b0, coin(), coin(), coin());
    send_sample(1'b0, 1'b0, coin(), coin(), coin());
    write_register(CFG_WAIT_LIMIT, 24'd1);
    send_arm();
    repeat (2) send_sample(1'b0, 1'b0, coin(), coin(), coin());
    write_register(CFG_WAIT_LIMIT, 24'd3);
    send_arm();
    repeat (4) send_sample(1'b0, 1'b0, coin(), coin(), coin());
    write_register(CFG_WAIT_LIMIT, {CFG_DATA_W{1'b1}});
    send_arm();
    repeat (6) send_sample(1'b0, 1'b0, coin(), coin(), coin());
    send_sample(1'b0, 1'b1, 1'b0, coin(), coin());
    send_line(1, 0);
    send_sample(1'b0, 1'b0, coin(), coin(), coin());
  endtask

  task automatic test_buffer_overflow();
    write_register(CFG_ROW_LENGTH, 24'd1285);
    send_arm();
    send_sample(1'b0, 1'b1, 1'b0, 1'b0, coin());
    repeat (51) send_line(0, 0);
    send_line(2, 0);
    send_sample(1'b0, 1'b0, coin(), coin(), coin());
  endtask

  task automatic test_random_capture();
    int                    idle_mix[4]  = '{0, 59, 0, 15};
    int                    stall_mix[4] = '{0, 0, 59, 15};
    int                    live_start;
    int                    result_start;
    int                    waits;
    logic [CFG_DATA_W-1:0] limit;
    logic [ROWLEN_W-1:0]   stride;
    for (int m = 0; m < 4; m++) begin
      case ($urandom_range(4))
        0:       limit = '0;
        1:       limit = 24'd1;
        2:       limit = {CFG_DATA_W{1'b1}};
        default: limit = CFG_DATA_W'($urandom_range(2, 12));
      endcase
      case ($urandom_range(5))
        0:       stride = '0;
        1:       stride = 11'd1;
        2:       stride = 11'd1024;
        3:       stride = '1;
        default: stride = ROWLEN_W'($urandom_range(2, 1023));
      endcase
      write_register(CFG_WAIT_LIMIT, limit);
      write_register(CFG_ROW_LENGTH, {13'($urandom), stride});
      sender_idle_pct    = idle_mix[m];
      receiver_stall_pct = stall_mix[m];
      live_start         = live_samples;
      result_start       = results_awaited;
      while (live_samples - live_start < 10 || results_awaited - result_start < 2) begin
        if ($urandom_range(9) == 0) begin
          send_noise($urandom_range(1, 6));
        end else begin
          if ($urandom_range(6) == 0 && wait_limit_q < 16) waits = int'(wait_limit_q) + 1;
          else waits = $urandom_range(0, 3);
          send_frame(waits, $urandom_range(1, 2), 1);
        end
      end
    end
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
  endtask

  task automatic test_output_hold_off();
    write_register(CFG_WAIT_LIMIT, '0);
    write_register(CFG_ROW_LENGTH, 24'd64);
    hold_toggle = ~hold_toggle;
    repeat (12) begin
      send_arm();
      send_sample(1'b0, 1'b0, coin(), coin(), coin());
    end
  endtask

  initial begin : test_sequence
    rst_ni             <= 1'b0;
    pix_ch.valid       <= 1'b0;
    pix_ch.mode        <= 1'b0;
    pix_ch.vsync       <= 1'b0;
    pix_ch.hsync       <= 1'b0;
    pix_ch.pixel_clock <= 1'b0;
    pix_ch.data_bit    <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_WAIT_LIMIT;
    cfg_ch.data        <= '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    wait_limit_q       = WAIT_W'(WAIT_RESET);
    row_length_q       = ROWLEN_W'(ROWLEN_RESET);
    cap_phase          = PH_IDLE;
    sync_wait          = '0;
    prev_pclk          = 1'b0;
    prev_hsync         = 1'b0;
    bit_pos            = '0;
    shift_reg          = '0;
    row_count          = '0;
    column_count       = '0;
    frame_count        = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_line_and_frame_ends();
    test_sync_timeout();
    test_buffer_overflow();
    test_random_capture();
    test_output_hold_off();
    wait_quiet();
    $display("Checked %0d results from %0d pin samples and arm commands in %0d cycles,",
             results_checked, samples_sent, cycle_count);
    $display("across %0d register writes, idle and stalled channels and a %0d-cycle hold-off.",
             settings_used, HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("serial_camera_pixel_capture_unit_tb: clean");
    end else begin
      $display("serial_camera_pixel_capture_unit_tb: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/scpc_pkg.sv
rtl/scpc_if.sv
rtl/scpc_front.sv
rtl/scpc_queue.sv
rtl/scpc_back.sv
rtl/serial_camera_pixel_capture_unit.sv
rtl/scpc_checker.sv
tb/sv/serial_camera_pixel_capture_unit_tb.sv
